[design/cprs_pkg.sv]
// Shared types and constants for the contiguous page run search block.
// No dependencies; imported by every module of the block.
`default_nettype none

package cprs_pkg;

  localparam int ADDR_W          = 52;
  localparam int CNT_W           = 41;
  localparam int PAGE_SHIFT      = 12;
  localparam int MAX_RANGES      = 4;
  localparam int RESERVED_RANGES = 4;

  // page numbers must hold ceil(addr / page) up to 2**(ADDR_W-PAGE_SHIFT)
  localparam int PG_W    = ADDR_W - PAGE_SHIFT + 1;
  localparam int SUM_W   = ((PG_W > CNT_W) ? PG_W : CNT_W) + 1;
  localparam int K_W     = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int PASS_W  = $clog2(MAX_RANGES + 1);
  localparam int CFG_IDX_W = 3;

  localparam logic [K_W-1:0]    LAST_K   = K_W'(RESERVED_RANGES - 1);
  localparam logic [PASS_W-1:0] MAX_PASS = PASS_W'(MAX_RANGES);

  typedef logic [PG_W-1:0]   page_t;
  typedef logic [SUM_W-1:0]  psum_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  count_t;

  // a reserved range kept as rounded-up page bounds
  typedef struct packed {
    page_t cb;
    page_t ce;
  } range_pg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R0_BEGIN = 3'd0,
    REG_R0_END   = 3'd1,
    REG_R1_BEGIN = 3'd2,
    REG_R1_END   = 3'd3,
    REG_R2_BEGIN = 3'd4,
    REG_R2_END   = 3'd5,
    REG_R3_BEGIN = 3'd6,
    REG_R3_END   = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_LIMIT,
    S_RNG_A,
    S_RNG_B,
    S_ADV,
    S_DONE
  } state_t;

  function automatic page_t ceil_page(input addr_t a);
    logic [ADDR_W:0] sum;
    sum = {1'b0, a} + (ADDR_W+1)'((64'd1 << PAGE_SHIFT) - 64'd1);
    return sum[ADDR_W:PAGE_SHIFT];
  endfunction

endpackage

`default_nettype wire

[design/cprs_cfg_regs.sv]
// Reserved range registers, stored as rounded-up page bounds.
// Depends on cprs_pkg.
`default_nettype none

module cprs_cfg_regs
  import cprs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire addr_t                   cfg_wdata,
  output range_pg_t [MAX_RANGES-1:0]   ranges_o
);

  range_pg_t [MAX_RANGES-1:0] ranges_r;
  page_t                      wr_pg;

  assign wr_pg    = ceil_page(cfg_wdata);
  assign ranges_o = ranges_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ranges_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_R0_BEGIN: ranges_r[0].cb <= wr_pg;
        REG_R0_END:   ranges_r[0].ce <= wr_pg;
        REG_R1_BEGIN: ranges_r[1].cb <= wr_pg;
        REG_R1_END:   ranges_r[1].ce <= wr_pg;
        REG_R2_BEGIN: ranges_r[2].cb <= wr_pg;
        REG_R2_END:   ranges_r[2].ce <= wr_pg;
        REG_R3_BEGIN: ranges_r[3].cb <= wr_pg;
        REG_R3_END:   ranges_r[3].ce <= wr_pg;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/cprs_seq.sv]
// Search sequencer: walks candidate start pages past reserved ranges,
// checking each range in S_RNG_A then S_RNG_B through a shared add/compare path.
// Depends on cprs_pkg.
`default_nettype none

module cprs_seq
  import cprs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire count_t                 page_count,
  input  wire addr_t                  region_base,
  input  wire addr_t                  region_limit,
  input  wire range_pg_t [MAX_RANGES-1:0] ranges,
  output logic                        res_valid,
  output logic                        res_found,
  output addr_t                       res_addr
);

  state_t              state_r, state_nxt;
  page_t               s_r;
  page_t               limit_r;
  count_t              n_r;
  logic                nz_r;
  psum_t               sn_r;
  logic [K_W-1:0]      k_r;
  logic [PASS_W-1:0]   pass_r;
  logic                moved_r;
  logic                live_r;
  page_t               lo_r;
  page_t               hi_r;
  logic                found_r;

  range_pg_t           rsel;
  logic                accept;
  logic                over_limit;
  logic                hit;
  logic                last_k;
  logic                moved_any;
  logic [PG_W+PAGE_SHIFT-1:0] addr_full;

  assign accept     = start && (state_r == S_IDLE);
  assign rsel       = ranges[k_r];
  assign over_limit = sn_r > SUM_W'(limit_r);
  assign hit        = live_r && nz_r && (SUM_W'(lo_r) < sn_r);
  assign last_k     = (k_r == LAST_K);
  // in S_ADV the move has already been recorded
  assign moved_any  = moved_r || (state_r == S_ADV);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_SUM;
      S_SUM:   state_nxt = S_LIMIT;
      S_LIMIT: state_nxt = over_limit ? S_DONE : S_RNG_A;
      S_RNG_A: state_nxt = S_RNG_B;
      S_RNG_B, S_ADV: begin
        if (state_r == S_RNG_B && hit) begin
          state_nxt = S_ADV;
        end else if (!last_k) begin
          state_nxt = S_RNG_A;
        end else if (moved_any && pass_r != MAX_PASS) begin
          state_nxt = S_LIMIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      found_r <= 1'b0;
      moved_r <= 1'b0;
      k_r     <= '0;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          found_r <= 1'b0;
          pass_r  <= '0;
        end
        S_LIMIT: begin
          k_r     <= '0;
          moved_r <= 1'b0;
          found_r <= 1'b0;
        end
        S_RNG_B, S_ADV: begin
          if (state_r == S_RNG_B && hit) begin
            moved_r <= 1'b1;
          end else if (!last_k) begin
            k_r <= k_r + K_W'(1);
          end else if (moved_any) begin
            pass_r <= pass_r + PASS_W'(1);
          end else begin
            // no range blocked this pass; the limit was checked at its start
            found_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s_r     <= PG_W'(region_base >> PAGE_SHIFT);
      limit_r <= PG_W'(region_limit >> PAGE_SHIFT);
      n_r     <= page_count;
      nz_r    <= (page_count != '0);
    end
    if (state_r == S_SUM || state_r == S_ADV) begin
      sn_r <= SUM_W'(s_r) + SUM_W'(n_r);
    end
    if (state_r == S_RNG_A) begin
      live_r <= (rsel.cb < rsel.ce) && (s_r < rsel.ce);
      lo_r   <= (rsel.cb == '0) ? '0 : rsel.cb - PG_W'(1);
      hi_r   <= rsel.ce;
    end
    if (state_r == S_RNG_B && hit) begin
      s_r <= hi_r;
    end
  end

  assign addr_full = {s_r, {PAGE_SHIFT{1'b0}}};

  always_comb begin
    busy      = (state_r != S_IDLE);
    res_valid = (state_r == S_DONE);
    res_found = found_r;
    res_addr  = found_r ? addr_full[ADDR_W-1:0] : '0;
  end

endmodule

`default_nettype wire

[design/contiguous_page_run_search.sv]
// Top level of the contiguous page run search block.
// Depends on cprs_pkg, cprs_cfg_regs and cprs_seq.
//
// Usage:
//   A request is taken when start is high while busy is low. It carries a
//   page count and a byte region [in_region_base, in_region_limit); both
//   addresses are truncated to whole pages. The block finds the lowest start
//   page of a run of that many pages inside the region that touches none of
//   the four reserved ranges, and reports it once: out_valid is high for one
//   cycle with out_found and out_run_address (zero when nothing fits).
//   The receiver cannot stall; the result must be taken in that cycle.
//   Each pass makes one limit compare, then checks the reserved ranges in turn
//   (S_RNG_A, then S_RNG_B), with an S_ADV step for each range that moves the
//   candidate; a range moves it at most once, so at most five passes and four
//   moves in all. busy stays high until the strobe cycle ends, so one request
//   is in flight at a time; the next one can be taken in the cycle after the
//   strobe. Reserved ranges are written through cfg_we/cfg_index/cfg_wdata;
//   the user must write them only while busy is low (the block does not
//   enforce it); each write is rounded to pages as it is stored.
//   Synchronous reset clears the ranges to empty and returns to idle.
`default_nettype none

module contiguous_page_run_search
  import cprs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CNT_W-1:0]     in_page_count,
  input  wire logic [ADDR_W-1:0]    in_region_base,
  input  wire logic [ADDR_W-1:0]    in_region_limit,
  output logic                      out_valid,
  output logic                      out_found,
  output logic [ADDR_W-1:0]         out_run_address,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_wdata
);

  range_pg_t [MAX_RANGES-1:0] ranges;

  cprs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ranges_o  (ranges)
  );

  cprs_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .page_count   (in_page_count),
    .region_base  (in_region_base),
    .region_limit (in_region_limit),
    .ranges       (ranges),
    .res_valid    (out_valid),
    .res_found    (out_found),
    .res_addr     (out_run_address)
  );

endmodule

`default_nettype wire

[dv/tb_contiguous_page_run_search.sv]
// Self-checking testbench for contiguous_page_run_search: directed table, then random phases.
// Needs cprs_pkg and the block's RTL; predicts each untyped request's first-fit run on its own.
`timescale 1ns / 1ps

module tb_contiguous_page_run_search;
  import cprs_pkg::*;

  localparam int     N_ROWS           = 19;
  localparam int     FIRST_RANGED_ROW = 10;
  localparam int     N_PHASES         = 10;
  localparam int     REQS_PER_PHASE   = 130;
  localparam int     STALL_LIMIT      = 1000;
  localparam int     DRAIN_CYCLES     = 80;
  localparam addr_t  ADDR_MAX         = '1;
  localparam count_t COUNT_MAX        = '1;
  localparam int     PAGE_BYTES       = 1 << PAGE_SHIFT;

  typedef struct packed {
    logic  found;
    addr_t addr;
  } run_result_t;

  typedef struct packed {
    count_t      pages;
    addr_t       base;
    addr_t       limit;
    logic        typed;
    run_result_t want;
  } probe_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  count_t   in_page_count = '0;
  addr_t    in_region_base = '0;
  addr_t    in_region_limit = '0;
  logic     out_valid;
  logic     out_found;
  addr_t    out_run_address;
  logic     cfg_we = 1'b0;
  cfg_reg_e cfg_index = REG_R0_BEGIN;
  addr_t    cfg_wdata = '0;

  // typed-in expectation travels with the request it belongs to
  logic        typed_pending = 1'b0;
  run_result_t typed_result = '0;

  addr_t       range_start [MAX_RANGES];
  addr_t       range_stop  [MAX_RANGES];
  addr_t       next_start  [MAX_RANGES];
  addr_t       next_stop   [MAX_RANGES];
  cfg_reg_e    start_reg   [MAX_RANGES] = '{REG_R0_BEGIN, REG_R1_BEGIN, REG_R2_BEGIN,
                                            REG_R3_BEGIN};
  cfg_reg_e    stop_reg    [MAX_RANGES] = '{REG_R0_END, REG_R1_END, REG_R2_END, REG_R3_END};
  run_result_t pending_runs [$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  bit          no_idle = 1'b0;
  addr_t       window;

  probe_t probe_rows [N_ROWS] = '{
    // reset config: no range reserves anything
    '{41'd1, 52'h0, 52'h1000, 1'b1, '{1'b1, 52'h0}},
    '{41'd0, 52'h5000, 52'h5000, 1'b1, '{1'b1, 52'h5000}},       // zero count
    '{41'd1, 52'h2000, 52'h1000, 1'b1, '{1'b0, 52'h0}},          // limit below base
    '{41'd0, 52'h3000, 52'h2fff, 1'b1, '{1'b0, 52'h0}},
    '{41'd2, 52'h1fff, 52'h3fff, 1'b1, '{1'b1, 52'h1000}},       // unaligned bounds
    '{COUNT_MAX, 52'h0, ADDR_MAX, 1'b1, '{1'b0, 52'h0}},
    '{41'h0ff_ffff_ffff, 52'h0, ADDR_MAX, 1'b1, '{1'b1, 52'h0}},
    '{41'h100_0000_0000, 52'h0, ADDR_MAX, 1'b1, '{1'b0, 52'h0}},
    '{41'd0, ADDR_MAX, ADDR_MAX, 1'b1, '{1'b1, 52'hf_ffff_ffff_f000}},
    '{41'd1, ADDR_MAX, ADDR_MAX, 1'b1, '{1'b0, 52'h0}},
    // ranged config, checked by the predictor
    '{41'd1, 52'h0, 52'h10000, 1'b0, '0},
    '{41'd2, 52'h0, 52'h10000, 1'b0, '0},
    '{41'd3, 52'h2000, 52'h8000, 1'b0, '0},
    '{41'd3, 52'h2000, 52'h7fff, 1'b0, '0},
    '{41'd0, 52'h3000, 52'h4000, 1'b0, '0},
    '{41'd1, 52'h8000, 52'h9000, 1'b0, '0},
    '{41'd5, 52'h0, ADDR_MAX, 1'b0, '0},
    '{41'h0ff_ffff_fffa, 52'h0, ADDR_MAX, 1'b0, '0},
    '{41'd1, 52'h4fff, 52'h6000, 1'b0, '0}
  };

  contiguous_page_run_search dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_page_count   (in_page_count),
    .in_region_base  (in_region_base),
    .in_region_limit (in_region_limit),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_run_address (out_run_address),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic addr_t rand_addr();
    return addr_t'({$urandom, $urandom});
  endfunction

  function automatic int unsigned jitter();
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, PAGE_BYTES - 1);
  endfunction

  // First-fit walk: skip past every blocking page interval, at most one pass per range + 1.
  function automatic run_result_t find_first_fit(input count_t pages, input addr_t base,
                                                 input addr_t limit);
    logic [63:0] cand, cnt, limit_pg, cb, ce, lo, hi, a, b;
    bit          moved;
    run_result_t res;
    cnt = 64'(pages);
    cand = 64'(base) >> PAGE_SHIFT;
    limit_pg = 64'(limit) >> PAGE_SHIFT;
    res = '0;
    for (int pass = 0; pass <= MAX_RANGES; pass++) begin
      if (cand + cnt > limit_pg) break;
      moved = 1'b0;
      for (int k = 0; k < RESERVED_RANGES; k++) begin
        cb = (64'(range_start[k]) + PAGE_BYTES - 1) >> PAGE_SHIFT;
        ce = (64'(range_stop[k]) + PAGE_BYTES - 1) >> PAGE_SHIFT;
        if (cb < ce) begin
          // a page is hit when its start or the next page's start is in the range
          lo = (cb > 0) ? cb - 1 : 64'd0;
          hi = ce;
          a = (lo > cand) ? lo : cand;
          b = (hi < cand + cnt) ? hi : cand + cnt;
          if (a < b) begin
            cand = hi;
            moved = 1'b1;
          end
        end
      end
      if (!moved) begin
        res.found = (cand + cnt <= limit_pg);
        break;
      end
    end
    if (res.found) res.addr = addr_t'(cand << PAGE_SHIFT);
    return res;
  endfunction

  // Result checking, expectation capture and config shadow, all on the same edge view.
  always @(posedge clk) begin : scoreboard
    run_result_t want;
    if (!rst_n) begin
      for (int k = 0; k < MAX_RANGES; k++) begin
        range_start[k] = '0;
        range_stop[k] = '0;
      end
    end else begin
      if (out_valid) begin
        if (pending_runs.size() == 0) begin
          $error("unexpected result: found=%0b run_address=%h", out_found, out_run_address);
          mismatch_count++;
        end else begin
          want = pending_runs.pop_front();
          if (out_found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, out_found);
            mismatch_count++;
          end
          if (out_run_address !== want.addr) begin
            $error("run_address: expected %h, got %h", want.addr, out_run_address);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        if (typed_pending) pending_runs.push_back(typed_result);
        else pending_runs.push_back(find_first_fit(in_page_count, in_region_base,
                                                   in_region_limit));
      end
      if (cfg_we) begin
        for (int k = 0; k < MAX_RANGES; k++) begin
          if (cfg_index == start_reg[k]) range_start[k] = cfg_wdata;
          if (cfg_index == stop_reg[k]) range_stop[k] = cfg_wdata;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Holds start until the block takes the request; start stays high on return.
  task automatic issue_request(input count_t pages, input addr_t base, input addr_t limit,
                               input logic typed, input run_result_t want);
    start <= 1'b1;
    in_page_count <= pages;
    in_region_base <= base;
    in_region_limit <= limit;
    typed_pending <= typed;
    typed_result <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap();
    int unsigned len;
    len = $urandom_range(1, 3);
    start <= 1'b0;
    in_page_count <= count_t'({$urandom, $urandom});
    in_region_base <= rand_addr();
    in_region_limit <= rand_addr();
    // sometimes let the search finish first so the gap lands on an idle block
    if ($urandom_range(0, 1) == 0) begin
      @(posedge clk);
      while (busy) @(posedge clk);
    end
    repeat (len) @(posedge clk);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_runs.size() != 0) @(posedge clk);
  endtask

  task automatic apply_ranges();
    wait_quiet();
    repeat (2) @(posedge clk);
    for (int k = 0; k < MAX_RANGES; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= start_reg[k];
      cfg_wdata <= next_start[k];
      @(posedge clk);
      cfg_index <= stop_reg[k];
      cfg_wdata <= next_stop[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_random_ranges();
    for (int k = 0; k < MAX_RANGES; k++) begin
      case ($urandom_range(0, 5))
        0: begin  // empty: begin at or above end
          next_start[k] = window + $urandom_range(0, 80) * PAGE_BYTES + jitter();
          next_stop[k] = next_start[k] - $urandom_range(0, 3) * PAGE_BYTES;
        end
        4: begin
          next_start[k] = rand_addr();
          next_stop[k] = rand_addr();
        end
        5: begin
          next_start[k] = ($urandom_range(0, 1) == 0) ? '0 : rand_addr() >> 4;
          next_stop[k] = ($urandom_range(0, 1) == 0) ? ADDR_MAX : window;
        end
        default: begin
          next_start[k] = window + $urandom_range(0, 80) * PAGE_BYTES + jitter();
          next_stop[k] = next_start[k] + $urandom_range(1, 20) * PAGE_BYTES + jitter();
        end
      endcase
    end
  endtask

  task automatic random_request();
    count_t pages;
    addr_t  base, limit;
    if ($urandom_range(0, 4) != 0) begin
      // mostly small runs inside the window where the ranges sit
      pages = ($urandom_range(0, 9) == 0) ? count_t'($urandom_range(0, 200))
                                         : count_t'($urandom_range(0, 10));
      base = window + $urandom_range(0, 100) * PAGE_BYTES + jitter();
      if ($urandom_range(0, 7) == 0) limit = base - $urandom_range(0, 3) * PAGE_BYTES;
      else limit = base + $urandom_range(0, 120) * PAGE_BYTES + jitter();
    end else begin
      pages = ($urandom_range(0, 1) == 0) ? count_t'({$urandom, $urandom})
                                         : count_t'($urandom_range(0, 64));
      base = rand_addr();
      limit = ($urandom_range(0, 1) == 0) ? rand_addr() : ADDR_MAX;
    end
    issue_request(pages, base, limit, 1'b0, '0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (i == FIRST_RANGED_ROW) begin
        // one range rounds to nothing, one has begin above end
        next_start = '{52'h3000, 52'h8001, 52'h20000, 52'h0};
        next_stop = '{52'h5000, 52'h9000, 52'h10000, 52'h1000};
        apply_ranges();
      end
      if ($urandom_range(0, 2) == 0) idle_gap();
      issue_request(probe_rows[i].pages, probe_rows[i].base, probe_rows[i].limit,
                    probe_rows[i].typed, probe_rows[i].want);
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      window = ($urandom_range(0, 3) == 0) ? '0 : (rand_addr() >> 1) & ~addr_t'(PAGE_BYTES - 1);
      pick_random_ranges();
      if (phase == 0) begin
        for (int k = 0; k < MAX_RANGES; k++) begin
          next_start[k] = ADDR_MAX;
          next_stop[k] = ADDR_MAX;
        end
      end else if (phase == 1) begin
        // whole address space reserved
        next_start[0] = '0;
        next_stop[0] = ADDR_MAX;
      end
      apply_ranges();
      no_idle = (phase == N_PHASES - 1);
      for (int j = 0; j < REQS_PER_PHASE; j++) begin
        if (!no_idle && $urandom_range(0, 2) == 0) idle_gap();
        random_request();
      end
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
